FILE: hdl/lsbe_pkg.sv
// ============================================================================
// Link spare bandwidth estimator package
// Shared widths, register indexes, sequencer states and divider interface.
// ============================================================================
`default_nettype none

package lsbe_pkg;

  localparam int WINDOW     = 15;
  localparam int RING_SIZE  = WINDOW + 1;
  localparam int IDX_W      = $clog2(RING_SIZE);
  localparam int CNT_W      = $clog2(WINDOW + 1);

  localparam int VAL_W      = 48;
  localparam int CNT_IN_W   = 32;
  localparam int TOT_W      = 33;
  localparam int PER_W      = 16;
  localparam int SCALE      = 10;
  localparam int MAG_W      = TOT_W + 4;
  localparam int DVD1_W     = MAG_W + 1;
  localparam int SUM_W      = VAL_W + CNT_W;
  localparam int DIV_W      = SUM_W;
  localparam int STEP_W     = $clog2(DIV_W + 1);
  localparam int FILL_W     = 4;
  localparam int EXT_W      = 8;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 48;
  localparam int IN_W       = 64;
  localparam int OUT_W      = 104;

  localparam logic [CFG_IDX_W-1:0] REG_LINK_SPEED     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REFRESH_PERIOD = 8'd1;
  localparam logic [PER_W-1:0]     PERIOD_RESET       = 16'd10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV1,
    ST_SPARE,
    ST_SUM,
    ST_DIV2,
    ST_OUT
  } lsbe_state_e;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
    logic [DIV_W-1:0]  dividend;
    logic [PER_W-1:0]  divisor;
  } lsbe_div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } lsbe_div_rsp_t;

endpackage

`default_nettype wire

FILE: hdl/lsbe_div.sv
// ============================================================================
// Shared bit-serial divider
// Restoring divider, one quotient bit per cycle. The dividend is loaded
// left-aligned; after the requested number of steps the quotient sits in the
// low bits of the result.
// ============================================================================
`default_nettype none

module lsbe_div
  import lsbe_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire lsbe_div_req_t req_i,
  output lsbe_div_rsp_t      rsp_o
);

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] step_q;
  logic [DIV_W-1:0]  a_q;
  logic [PER_W-1:0]  r_q;
  logic [PER_W-1:0]  d_q;

  logic [PER_W:0]    shifted;
  logic [PER_W:0]    trial;
  logic              qbit;
  logic [PER_W-1:0]  r_d;

  always_comb begin
    shifted = {r_q, a_q[DIV_W-1]};
    trial   = shifted - {1'b0, d_q};
    qbit    = ~trial[PER_W];
    r_d     = qbit ? trial[PER_W-1:0] : shifted[PER_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= req_i.steps;
      end else if (busy_q) begin
        step_q <= step_q - STEP_W'(1);
        if (step_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q <= req_i.dividend;
      r_q <= '0;
      d_q <= req_i.divisor;
    end else if (busy_q) begin
      a_q <= {a_q[DIV_W-2:0], qbit};
      r_q <= r_d;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = a_q;

endmodule

`default_nettype wire

FILE: hdl/link_spare_bandwidth_estimator.sv
// ============================================================================
// Link spare bandwidth estimator
// Per-sample spare bandwidth and windowed mean over a small value ring.
// ============================================================================
// Each input item is a sample of the rx and tx byte counters. The block takes
// one item at a time: after an accept, s_axis_tready stays low until the
// result has been loaded into the output register. From one accept to the
// next possible accept an item goes through the delta division, forming the
// spare value, adding up the averaged ring entries into the window sum, the
// mean division, loading the output register and one idle step. The first
// sample skips the delta division. Both divisions share the single bit-serial
// divider. A finished result may wait in the output register while the next
// item is accepted; if it is still waiting when the next result is ready, the
// block holds in its last step. Config writes are always ready and must only
// be issued while the block is idle.
`default_nettype none

module link_spare_bandwidth_estimator
  import lsbe_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // config write channel
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  // input items
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_W-1:0]       s_axis_tdata,  // rx_bytes[31:0], tx_bytes[63:32]
  // result items
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OUT_W-1:0]           m_axis_tdata   // sample_spare[47:0],
                                                    // average_spare[95:48],
                                                    // window_fill[99:96], zero pad
);

  lsbe_state_e state_q, state_d;

  logic [VAL_W-1:0]  speed_q;
  logic [PER_W-1:0]  period_q;
  logic [TOT_W-1:0]  prev_q;
  logic [IDX_W-1:0]  wp_q;
  logic [IDX_W-1:0]  rp_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [CNT_W-1:0]  left_q;
  logic              pend_q;
  logic              first_q;
  logic              neg_q;
  logic [VAL_W-1:0]  spare_q;
  logic [SUM_W-1:0]  sum_q;
  logic [VAL_W-1:0]  rd_data_q;
  logic              out_valid_q;
  logic [OUT_W-1:0]  out_data_q;

  logic [VAL_W-1:0]  ring_mem [RING_SIZE];

  lsbe_div_req_t     div_req;
  lsbe_div_rsp_t     div_rsp;

  logic              accept;
  logic [TOT_W-1:0]  total;
  logic              neg;
  logic [TOT_W-1:0]  delta;
  logic [MAG_W-1:0]  mag;
  logic [PER_W-1:0]  div_eff;
  logic [DVD1_W-1:0] dvd1;
  logic [DVD1_W-1:0] quot1;
  logic [VAL_W:0]    up_sum;
  logic [VAL_W-1:0]  spare_calc;
  logic [CNT_W-1:0]  cnt_new;
  logic [IDX_W-1:0]  wp_next;
  logic [IDX_W-1:0]  wp_prev;
  logic [IDX_W-1:0]  rp_prev;
  logic [EXT_W-1:0]  cnt_ext;
  logic              out_free;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign out_free      = !out_valid_q || m_axis_tready;

  // delta and first dividend
  always_comb begin
    total   = TOT_W'(s_axis_tdata[CNT_IN_W-1:0]) + TOT_W'(s_axis_tdata[IN_W-1:CNT_IN_W]);
    neg     = (total < prev_q);
    delta   = neg ? (prev_q - total) : (total - prev_q);
    mag     = MAG_W'(delta) * MAG_W'(SCALE);
    div_eff = (period_q == '0) ? PER_W'(1) : period_q;
    dvd1    = neg ? DVD1_W'(mag)
                  : (DVD1_W'(mag) + DVD1_W'(div_eff) - DVD1_W'(1));
  end

  // spare from quotient, or the link speed for the first sample
  always_comb begin
    quot1  = div_rsp.quotient[DVD1_W-1:0];
    up_sum = {1'b0, speed_q} + (VAL_W + 1)'(quot1);
    if (first_q) begin
      spare_calc = speed_q;
    end else if (neg_q) begin
      spare_calc = up_sum[VAL_W] ? {VAL_W{1'b1}} : up_sum[VAL_W-1:0];
    end else begin
      spare_calc = (speed_q >= VAL_W'(quot1)) ? (speed_q - VAL_W'(quot1)) : '0;
    end
  end

  always_comb begin
    cnt_new = (cnt_q < CNT_W'(WINDOW)) ? (cnt_q + CNT_W'(1)) : cnt_q;
    wp_next = (wp_q == IDX_W'(RING_SIZE - 1)) ? '0 : (wp_q + IDX_W'(1));
    wp_prev = (wp_q == '0) ? IDX_W'(RING_SIZE - 1) : (wp_q - IDX_W'(1));
    rp_prev = (rp_q == '0) ? IDX_W'(RING_SIZE - 1) : (rp_q - IDX_W'(1));
    cnt_ext = EXT_W'(cnt_q);
  end

  // sequencer
  always_comb begin
    state_d          = state_q;
    div_req.start    = 1'b0;
    div_req.steps    = STEP_W'(DVD1_W);
    div_req.dividend = {dvd1, {(DIV_W - DVD1_W){1'b0}}};
    div_req.divisor  = div_eff;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (cnt_q == '0) begin
            state_d = ST_SPARE;
          end else begin
            div_req.start = 1'b1;
            state_d       = ST_DIV1;
          end
        end
      end
      ST_DIV1: begin
        if (div_rsp.done) begin
          state_d = ST_SPARE;
        end
      end
      ST_SPARE: begin
        state_d = ST_SUM;
      end
      ST_SUM: begin
        if (left_q == '0 && !pend_q) begin
          div_req.start    = 1'b1;
          div_req.steps    = STEP_W'(DIV_W);
          div_req.dividend = sum_q;
          div_req.divisor  = PER_W'(cnt_q);
          state_d          = ST_DIV2;
        end
      end
      ST_DIV2: begin
        if (div_rsp.done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  lsbe_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      speed_q     <= '0;
      period_q    <= PERIOD_RESET;
      prev_q      <= '0;
      wp_q        <= '0;
      rp_q        <= '0;
      cnt_q       <= '0;
      left_q      <= '0;
      pend_q      <= 1'b0;
      first_q     <= 1'b0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_LINK_SPEED:     speed_q  <= cfg_data_i[VAL_W-1:0];
          REG_REFRESH_PERIOD: period_q <= cfg_data_i[PER_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        prev_q  <= total;
        first_q <= (cnt_q == '0);
        neg_q   <= neg;
      end
      pend_q <= (state_q == ST_SUM) && (left_q != '0);
      case (state_q)
        ST_SPARE: begin
          wp_q   <= wp_next;
          rp_q   <= wp_prev;
          cnt_q  <= cnt_new;
          left_q <= cnt_new - CNT_W'(1);
        end
        ST_SUM: begin
          if (left_q != '0) begin
            rp_q   <= rp_prev;
            left_q <= left_q - CNT_W'(1);
          end
        end
        default: ;
      endcase
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_SPARE) begin
      spare_q <= spare_calc;
      sum_q   <= SUM_W'(spare_calc);
    end else if (state_q == ST_SUM && pend_q) begin
      sum_q <= sum_q + SUM_W'(rd_data_q);
    end
    if (state_q == ST_OUT && out_free) begin
      out_data_q <= {{(OUT_W - 2 * VAL_W - FILL_W){1'b0}}, cnt_ext[FILL_W-1:0],
                     div_rsp.quotient[VAL_W-1:0], spare_q};
    end
  end

  // value ring
  always_ff @(posedge clk_i) begin
    if (state_q == ST_SPARE) begin
      ring_mem[wp_q] <= spare_calc;
    end
    rd_data_q <= ring_mem[rp_q];
  end

endmodule

`default_nettype wire

FILE: hdl/lsbe_chk.sv
// ============================================================================
// Link spare bandwidth estimator port checker
// Concurrent checks on the top-level ports, bound to the top level.
// ============================================================================
`default_nettype none

module lsbe_chk
  import lsbe_pkg::*;
(
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  s_axis_tvalid,
  input wire logic                  s_axis_tready,
  input wire logic                  m_axis_tvalid,
  input wire logic                  m_axis_tready,
  input wire logic [OUT_W-1:0]      m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result item changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while an item is in progress");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OUT_W-1:2*VAL_W+FILL_W] == '0)
    else $error("result padding not zero");

  a_single_mean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2*VAL_W+FILL_W-1:2*VAL_W] == FILL_W'(1)
    |-> m_axis_tdata[2*VAL_W-1:VAL_W] == m_axis_tdata[VAL_W-1:0])
    else $error("mean of one entry differs from the sample");

endmodule

bind link_spare_bandwidth_estimator lsbe_chk u_lsbe_chk (.*);

`default_nettype wire

FILE: dv/tb_link_spare_bandwidth_estimator.sv
`timescale 1ns / 100ps
// ============================================================================
// Link spare bandwidth estimator testbench
// Streams counter samples into the block under random idling on both sides,
// tracks spare bandwidth and the windowed mean in a local model, and compares
// every result item field by field in arrival order.
// ============================================================================
module tb_link_spare_bandwidth_estimator;
  import lsbe_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int STALL_LEN   = 3000;
  localparam int DRAIN_WAIT  = 200;
  localparam logic [VAL_W-1:0] VAL_MAX = '1;

  typedef struct packed {
    logic [VAL_W-1:0]  sample_spare;
    logic [VAL_W-1:0]  average_spare;
    logic [FILL_W-1:0] window_fill;
  } report_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_W-1:0]       s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_W-1:0]      m_axis_tdata;

  // model state
  logic [VAL_W-1:0] link_speed_q = '0;
  logic [PER_W-1:0] period_q     = PERIOD_RESET;
  logic [VAL_W-1:0] spare_ring_q [RING_SIZE];
  logic [TOT_W-1:0] prev_total_q = '0;
  int unsigned      wr_pos_q     = 0;
  int unsigned      fill_q       = 0;

  report_t expected_reports[$];
  report_t head_report;
  int      mismatches  = 0;
  int      cycle_count = 0;
  int      snd_idle_pct = 0;
  int      rcv_idle_pct = 0;
  bit      stall_req    = 1'b0;
  bit      stall_done   = 1'b0;
  int      stall_cnt    = 0;
  logic [31:0] rx_ctr = '0;
  logic [31:0] tx_ctr = '0;

  link_spare_bandwidth_estimator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic report_t estimate_spare(input logic [31:0] rx, input logic [31:0] tx);
    logic [TOT_W-1:0] total;
    logic [VAL_W-1:0] spare;
    logic [63:0]      div;
    logic [63:0]      mag;
    logic [63:0]      quo;
    logic [63:0]      acc;
    int unsigned      k;
    report_t          r;
    total = {1'b0, rx} + {1'b0, tx};
    if (fill_q == 0) begin
      spare = link_speed_q;
    end else begin
      div = (period_q == '0) ? 64'd1 : {48'd0, period_q};
      if (total >= prev_total_q) begin
        mag = 64'(total - prev_total_q);
        mag = mag * 64'(SCALE);
        quo = (mag + div - 64'd1) / div;
        acc = 64'(link_speed_q);
        spare = (acc >= quo) ? link_speed_q - quo[VAL_W-1:0] : '0;
      end else begin
        mag = 64'(prev_total_q - total);
        mag = mag * 64'(SCALE);
        quo = mag / div;
        acc = 64'(VAL_MAX - link_speed_q);
        spare = (quo > acc) ? VAL_MAX : link_speed_q + quo[VAL_W-1:0];
      end
    end
    spare_ring_q[IDX_W'(wr_pos_q)] = spare;
    prev_total_q = total;
    wr_pos_q = (wr_pos_q + 1) % RING_SIZE;
    if (fill_q < WINDOW) fill_q++;
    acc = '0;
    for (k = 1; k <= fill_q; k++) begin
      acc = acc + 64'(spare_ring_q[IDX_W'((wr_pos_q + RING_SIZE - k) % RING_SIZE)]);
    end
    acc = acc / 64'(fill_q);
    r.sample_spare  = spare;
    r.average_spare = acc[VAL_W-1:0];
    r.window_fill   = fill_q[FILL_W-1:0];
    return r;
  endfunction

  function automatic void flag_mismatch(input string what, input logic [63:0] want,
                                        input logic [63:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, what, want, got);
  endfunction

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_reports.size() == 0) begin
        flag_mismatch("unexpected item", '0, m_axis_tdata[63:0]);
      end else begin
        head_report = expected_reports.pop_front();
        if (m_axis_tdata[47:0] !== head_report.sample_spare)
          flag_mismatch("sample_spare", 64'(head_report.sample_spare),
                        64'(m_axis_tdata[47:0]));
        if (m_axis_tdata[95:48] !== head_report.average_spare)
          flag_mismatch("average_spare", 64'(head_report.average_spare),
                        64'(m_axis_tdata[95:48]));
        if (m_axis_tdata[99:96] !== head_report.window_fill)
          flag_mismatch("window_fill", 64'(head_report.window_fill),
                        64'(m_axis_tdata[99:96]));
      end
    end
  end

  // result receiver, with one long hold-off on request
  always @(negedge clk_i) begin
    if (stall_req && !stall_done) begin
      m_axis_tready = 1'b0;
      stall_cnt++;
      if (stall_cnt == STALL_LEN) stall_done = 1'b1;
    end else begin
      m_axis_tready = ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  task automatic send_sample(input logic [31:0] rx, input logic [31:0] tx);
    @(negedge clk_i);
    while ($urandom_range(99) < snd_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {tx, rx};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_reports.push_back(estimate_spare(rx, tx));
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == REG_LINK_SPEED) link_speed_q = data;
    else if (idx == REG_REFRESH_PERIOD) period_q = data[PER_W-1:0];
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic test_first_sample();
    // reset config: zero speed, default period
    send_sample(32'd0, 32'd0);
    send_sample(32'd5, 32'd0);
    send_sample(32'd0, 32'd0);
    wait_idle();
  endtask

  task automatic test_counter_extremes();
    write_register(REG_LINK_SPEED, 48'd1000000);
    write_register(REG_REFRESH_PERIOD, 48'd3);
    send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_sample(32'd0, 32'd0);
    send_sample(32'd1, 32'd0);
    send_sample(32'd1, 32'hFFFF_FFFF);
    send_sample(32'h8000_0000, 32'h7FFF_FFFF);
    wait_idle();
  endtask

  task automatic test_saturation();
    write_register(REG_LINK_SPEED, VAL_MAX);
    write_register(REG_REFRESH_PERIOD, 48'd1);
    send_sample(32'hFFFF_FFFF, 32'd0);
    send_sample(32'd0, 32'd0);
    send_sample(32'd0, 32'd0);
    send_sample(32'd1, 32'd0);
    wait_idle();
  endtask

  task automatic test_zero_period();
    write_register(REG_LINK_SPEED, 48'd5000);
    write_register(REG_REFRESH_PERIOD, 48'd0);
    send_sample(32'd100, 32'd0);
    send_sample(32'd50, 32'd0);
    wait_idle();
    write_register(REG_REFRESH_PERIOD, 48'hFFFF);
    send_sample(32'd50, 32'h0001_0000);
    send_sample(32'hFFFF_FFFF, 32'h1234_5678);
    wait_idle();
  endtask

  task automatic test_ring_wrap();
    int i;
    write_register(REG_LINK_SPEED, 48'd1000000);
    write_register(REG_REFRESH_PERIOD, {32'd0, PERIOD_RESET});
    for (i = 0; i < 8; i++) begin
      rx_ctr = rx_ctr + 20000 * i;
      tx_ctr = tx_ctr + 3000;
      send_sample(rx_ctr, tx_ctr);
    end
    wait_idle();
  endtask

  task automatic pick_setting();
    logic [63:0] speed;
    logic [15:0] period;
    case ($urandom_range(4))
      0: speed = '0;
      1: speed = 64'(VAL_MAX);
      2: speed = 64'd1250000000;
      3: speed = {$urandom, $urandom};
      default: speed = 64'($urandom_range(100000));
    endcase
    case ($urandom_range(4))
      0: period = '0;
      1: period = 16'd1;
      2: period = PERIOD_RESET;
      3: period = 16'hFFFF;
      default: period = 16'($urandom);
    endcase
    write_register(REG_LINK_SPEED, speed[CFG_DATA_W-1:0]);
    write_register(REG_REFRESH_PERIOD, {32'd0, period});
  endtask

  task automatic test_random_traffic();
    int phase;
    int seg;
    int n;
    int sel;
    logic [63:0] budget;
    logic [63:0] lim;
    logic [31:0] d;
    logic [31:0] part;
    for (phase = 0; phase < 3; phase++) begin
      snd_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 73 : 0;
      rcv_idle_pct = (phase == 0) ? 73 : (phase == 1) ? 8 : 0;
      for (seg = 0; seg < 3; seg++) begin
        wait_idle();
        pick_setting();
        for (n = 0; n < 145; n++) begin
          sel = $urandom_range(99);
          if (sel < 8) begin
            rx_ctr = $urandom;
            tx_ctr = $urandom;
          end else if (sel < 13) begin
            // counter restart
            rx_ctr = $urandom_range(1000);
            tx_ctr = $urandom_range(1000);
          end else begin
            budget = 64'(link_speed_q) * 64'((period_q == '0) ? 16'd1 : period_q)
                     / 64'(SCALE);
            lim = budget + budget / 4;
            if ($urandom_range(3) == 0) lim = lim / 64;
            if (lim > 64'hFFFF_FFFF) lim = 64'hFFFF_FFFF;
            d = $urandom_range(lim[31:0], 0);
            part = $urandom_range(d, 0);
            rx_ctr = rx_ctr + part;
            tx_ctr = tx_ctr + (d - part);
          end
          send_sample(rx_ctr, tx_ctr);
        end
      end
    end
    wait_idle();
  endtask

  task automatic test_output_stall();
    int i;
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    write_register(REG_LINK_SPEED, 48'd1000000000);
    write_register(REG_REFRESH_PERIOD, {32'd0, PERIOD_RESET});
    stall_req = 1'b1;
    for (i = 0; i < 24; i++) begin
      rx_ctr = rx_ctr + $urandom_range(800000000);
      tx_ctr = tx_ctr + $urandom_range(400000000);
      send_sample(rx_ctr, tx_ctr);
    end
    wait_idle();
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    test_first_sample();
    test_counter_extremes();
    test_saturation();
    test_zero_period();
    test_ring_wrap();
    test_random_traffic();
    test_output_stall();

    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
